/* sv/ttb_pkg.sv */
`default_nettype none
package ttb_pkg;
    localparam int CoordW = 16;
    localparam int DeltaW = 17;
    localparam int ProdW  = 34;
    localparam int VecW   = 35;
    localparam int MagW   = 34;
    localparam int NormW  = 30;
    localparam int SumW   = 62;
    localparam int RootW  = 31;
    localparam int OutW   = 16;
    localparam int InDataW  = 80;
    localparam int OutDataW = 96;
    localparam int UnitOne  = 16384;
endpackage
`default_nettype wire

/* sv/triangle_tangent_bitangent_top.sv */
// The third corner of a triangle starts the computation, which ends early with a degenerate result
// or runs through normalize, square, square root and divide for a full basis.
// The first two corners give no result.
// One triangle at a time: no corners are taken until the computation is done; the serial
// multiply, square, square root and divide steps run one after another.
// The finished result waits in an output register; corners are taken meanwhile while idle.
// Reset (rst_n low, asynchronous) clears the state, the corner count and the output valid flag.
`default_nettype none
module triangle_tangent_bitangent_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v
    input  wire logic [79:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z
    output logic [95:0]      m_tdata,
    // degenerate
    output logic             m_tuser
);
    import ttb_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL  = 9'b000000010,
        S_VEC  = 9'b000000100,
        S_NORM = 9'b000001000,
        S_SQ   = 9'b000010000,
        S_SQRT = 9'b000100000,
        S_DIV  = 9'b001000000,
        S_NEXT = 9'b010000000,
        S_OUT  = 9'b100000000
    } state_t;

    state_t state_reg;
    logic [1:0] count_reg;
    logic signed [CoordW-1:0] hp_reg [6];
    logic signed [CoordW-1:0] ht_reg [4];
    logic signed [DeltaW-1:0] d_reg [10]; // dp1 xyz, dp2 xyz, du1 dv1 du2 dv2
    logic signed [ProdW-1:0] prod_reg [14];
    logic signed [VecW-1:0] vec_reg [6];
    logic signed [VecW:0] det_reg;
    logic [4:0] pidx_reg;
    logic [5:0] bcnt_reg;
    // shift-add multiplier
    logic [ProdW-1:0] macc_reg;
    logic [DeltaW-1:0] mplr_reg;
    logic [ProdW-1:0] mcand_reg;
    logic mneg_reg;
    // normalize of one vector
    logic vsel_reg;
    logic [1:0] cidx_reg;
    logic [MagW-1:0] mag_reg [3];
    logic neg_reg [3];
    logic [SumW-1:0] sum_reg;
    logic [SumW-1:0] rem_reg;
    logic [SumW-1:0] root_reg;
    logic [SumW+1:0] bit_reg;
    logic [NormW+14:0] dnum_reg;
    logic [RootW:0] drem_reg;
    logic [OutW-1:0] res_reg [6];
    logic deg_reg;
    logic out_v_reg;
    logic [OutW-1:0] out_res_reg [6];
    logic out_deg_reg;

    function automatic logic signed [DeltaW-1:0] sub16(input logic signed [CoordW-1:0] a,
                                                       input logic signed [CoordW-1:0] b);
        sub16 = DeltaW'(a) - DeltaW'(b);
    endfunction

    // operand pairs for the fourteen products
    logic [3:0] op_a, op_b;
    always_comb
    begin
        op_a = 4'd0; op_b = 4'd0;
        case (pidx_reg)
            5'd0: begin op_a = 4'd6; op_b = 4'd9; end
            5'd1: begin op_a = 4'd8; op_b = 4'd7; end
            5'd2: begin op_a = 4'd0; op_b = 4'd9; end
            5'd3: begin op_a = 4'd3; op_b = 4'd7; end
            5'd4: begin op_a = 4'd1; op_b = 4'd9; end
            5'd5: begin op_a = 4'd4; op_b = 4'd7; end
            5'd6: begin op_a = 4'd2; op_b = 4'd9; end
            5'd7: begin op_a = 4'd5; op_b = 4'd7; end
            5'd8: begin op_a = 4'd3; op_b = 4'd6; end
            5'd9: begin op_a = 4'd0; op_b = 4'd8; end
            5'd10: begin op_a = 4'd4; op_b = 4'd6; end
            5'd11: begin op_a = 4'd1; op_b = 4'd8; end
            5'd12: begin op_a = 4'd5; op_b = 4'd6; end
            5'd13: begin op_a = 4'd2; op_b = 4'd8; end
            default: begin op_a = 4'd0; op_b = 4'd0; end
        endcase
    end

    logic signed [DeltaW-1:0] ma, mb;
    assign ma = d_reg[op_a];
    assign mb = d_reg[op_b];

    logic signed [VecW:0] det_w;
    assign det_w = (VecW+1)'(prod_reg[0]) - (VecW+1)'(prod_reg[1]);

    logic accept;
    assign s_tready = (state_reg == S_IDLE);
    assign accept = s_tvalid && s_tready;

    logic signed [CoordW-1:0] in_f [5];
    always_comb
    begin
        for (int i = 0; i < 5; i++)
            in_f[i] = s_tdata[i*16 +: 16];
    end

    // OR of the magnitudes has the same leading bit as their max
    logic [MagW-1:0] big;
    always_comb
    begin
        big = '0;
        for (int i = 0; i < 3; i++)
            big = big | mag_reg[i];
    end

    logic [SumW-1:0] try_w;
    assign try_w = root_reg + bit_reg[SumW-1:0];
    logic [RootW:0] dsh;
    assign dsh = {drem_reg[RootW-1:0], dnum_reg[NormW+14]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= 2'd0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (out_v_reg && m_tready) out_v_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (accept)
                    begin
                        if (count_reg != 2'd2)
                        begin
                            count_reg <= count_reg + 2'd1;
                        end
                        else
                        begin
                            count_reg <= 2'd0;
                            state_reg <= S_MUL;
                        end
                    end
                S_MUL:
                    if (bcnt_reg == 6'(DeltaW+1) && pidx_reg == 5'd13) state_reg <= S_VEC;
                S_VEC:
                    state_reg <= (det_w == 0) ? S_OUT : S_NORM;
                S_NORM:
                    if (bcnt_reg == 6'd63 && (big == 0 ||
                        (big < (MagW'(1) << 30) && big >= (MagW'(1) << 29))))
                        state_reg <= (big == 0) ? S_NEXT : S_SQ;
                S_SQ:
                    if (bcnt_reg == 6'(NormW) && cidx_reg == 2'd2) state_reg <= S_SQRT;
                S_SQRT:
                    if (bit_reg == 0) state_reg <= S_DIV;
                S_DIV:
                    if (bcnt_reg == 6'(NormW+15) && cidx_reg == 2'd2) state_reg <= S_NEXT;
                S_NEXT:
                    state_reg <= vsel_reg ? S_OUT : S_NORM;
                S_OUT:
                    if (!out_v_reg)
                    begin
                        out_v_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    if (count_reg != 2'd2)
                    begin
                        for (int i = 0; i < 3; i++) hp_reg[count_reg[0]*3 + i] <= in_f[i];
                        ht_reg[count_reg[0]*2]     <= in_f[3];
                        ht_reg[count_reg[0]*2 + 1] <= in_f[4];
                    end
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            d_reg[i]   <= sub16(hp_reg[3+i], hp_reg[i]);
                            d_reg[3+i] <= sub16(in_f[i], hp_reg[i]);
                        end
                        d_reg[6] <= sub16(ht_reg[2], ht_reg[0]);
                        d_reg[7] <= sub16(ht_reg[3], ht_reg[1]);
                        d_reg[8] <= sub16(in_f[3], ht_reg[0]);
                        d_reg[9] <= sub16(in_f[4], ht_reg[1]);
                        pidx_reg <= 5'd0;
                        bcnt_reg <= 6'd0;
                        vsel_reg <= 1'b0;
                    end
                end
            S_MUL:
            begin
                // one multiplier bit per cycle on magnitudes, sign fixed at the end
                if (bcnt_reg == 6'd0)
                begin
                    macc_reg  <= '0;
                    mplr_reg  <= ma[DeltaW-1] ? DeltaW'(-ma) : DeltaW'(ma);
                    mcand_reg <= mb[DeltaW-1] ? ProdW'(-DeltaW'(mb)) & {{(ProdW-DeltaW){1'b0}},
                                 {DeltaW{1'b1}}} : ProdW'(DeltaW'(mb));
                    mneg_reg  <= ma[DeltaW-1] ^ mb[DeltaW-1];
                    bcnt_reg  <= 6'd1;
                end
                else if (bcnt_reg != 6'(DeltaW+1))
                begin
                    if (mplr_reg[0]) macc_reg <= macc_reg + mcand_reg;
                    mplr_reg  <= mplr_reg >> 1;
                    mcand_reg <= mcand_reg << 1;
                    bcnt_reg  <= bcnt_reg + 6'd1;
                end
                else
                begin
                    prod_reg[pidx_reg[3:0]] <= mneg_reg ? -$signed(macc_reg) : $signed(macc_reg);
                    pidx_reg <= pidx_reg + 5'd1;
                    bcnt_reg <= 6'd0;
                end
            end
            S_VEC:
            begin
                det_reg <= det_w;
                for (int i = 0; i < 3; i++)
                begin
                    vec_reg[i]   <= VecW'(prod_reg[2+2*i]) - VecW'(prod_reg[3+2*i]);
                    vec_reg[3+i] <= VecW'(prod_reg[8+2*i]) - VecW'(prod_reg[9+2*i]);
                end
                deg_reg <= (det_w == 0);
                vsel_reg <= 1'b0;
            end
            S_NORM:
            begin
                if (bcnt_reg != 6'd63)
                begin
                    // load magnitudes of the selected vector
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_reg[i] <= vec_reg[vsel_reg*3+i][VecW-1] ?
                                      MagW'(-vec_reg[vsel_reg*3+i]) : MagW'(vec_reg[vsel_reg*3+i]);
                        neg_reg[i] <= vec_reg[vsel_reg*3+i][VecW-1] ^ det_reg[VecW];
                    end
                    bcnt_reg <= 6'd63;
                end
                else if (big != 0 && big < (MagW'(1) << 29))
                begin
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] << 1;
                end
                else if (big >= (MagW'(1) << 30))
                begin
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
                end
                else
                begin
                    sum_reg  <= '0;
                    cidx_reg <= 2'd0;
                    bcnt_reg <= 6'd0;
                    if (big == 0)
                        for (int i = 0; i < 3; i++) res_reg[vsel_reg*3+i] <= '0;
                end
            end
            S_SQ:
            begin
                // squares by shift-add, one bit per cycle
                if (bcnt_reg == 6'd0)
                begin
                    macc_reg <= '0;
                    mcand_reg <= '0;
                    dnum_reg <= (NormW+15)'(mag_reg[cidx_reg]);
                    bcnt_reg <= 6'd1;
                    rem_reg <= SumW'(mag_reg[cidx_reg][NormW-1:0]);
                    root_reg <= '0;
                end
                else if (bcnt_reg != 6'(NormW))
                begin
                    if (dnum_reg[0])
                        sum_reg <= sum_reg + rem_reg;
                    dnum_reg <= dnum_reg >> 1;
                    rem_reg  <= rem_reg << 1;
                    bcnt_reg <= bcnt_reg + 6'd1;
                end
                else
                begin
                    bcnt_reg <= 6'd0;
                    cidx_reg <= cidx_reg + 2'd1;
                    if (cidx_reg == 2'd2)
                    begin
                        rem_reg  <= dnum_reg[0] ? sum_reg + rem_reg : sum_reg;
                        root_reg <= '0;
                        bit_reg  <= (SumW+2)'(1) << 60;
                    end
                    else if (dnum_reg[0])
                        sum_reg <= sum_reg + rem_reg;
                end
            end
            S_SQRT:
            begin
                if (bit_reg != 0)
                begin
                    if (rem_reg >= try_w)
                    begin
                        rem_reg  <= rem_reg - try_w;
                        root_reg <= (root_reg >> 1) + bit_reg[SumW-1:0];
                    end
                    else
                        root_reg <= root_reg >> 1;
                    bit_reg <= bit_reg >> 2;
                end
                if (bit_reg == 0)
                begin
                    cidx_reg <= 2'd0;
                    bcnt_reg <= 6'd0;
                end
            end
            S_DIV:
            begin
                // restoring divide of mag*16384 + n/2 by n, one quotient bit per cycle
                if (bcnt_reg == 6'd0)
                begin
                    dnum_reg <= ((NormW+15)'(mag_reg[cidx_reg]) << 14) +
                                (NormW+15)'(root_reg >> 1);
                    drem_reg <= '0;
                    bcnt_reg <= 6'd1;
                end
                else if (bcnt_reg <= 6'(NormW+15))
                begin
                    if (dsh >= (RootW+1)'(root_reg))
                    begin
                        drem_reg <= dsh - (RootW+1)'(root_reg);
                        dnum_reg <= {dnum_reg[NormW+13:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= dsh;
                        dnum_reg <= {dnum_reg[NormW+13:0], 1'b0};
                    end
                    if (bcnt_reg == 6'(NormW+15))
                    begin
                        res_reg[vsel_reg*3+cidx_reg] <= neg_reg[cidx_reg] ?
                            OutW'(-{dnum_reg[OutW-2:0], dsh >= (RootW+1)'(root_reg)}) :
                            OutW'({dnum_reg[OutW-2:0], dsh >= (RootW+1)'(root_reg)});
                        cidx_reg <= cidx_reg + 2'd1;
                        bcnt_reg <= 6'd0;
                    end
                    else
                        bcnt_reg <= bcnt_reg + 6'd1;
                end
            end
            S_NEXT:
            begin
                vsel_reg <= 1'b1;
                bcnt_reg <= 6'd0;
            end
            S_OUT:
                if (!out_v_reg)
                begin
                    // a degenerate triangle drives both vectors to zero
                    for (int i = 0; i < 6; i++) out_res_reg[i] <= deg_reg ? '0 : res_reg[i];
                    out_deg_reg <= deg_reg;
                end
            default: ;
        endcase
    end

    assign m_tvalid = out_v_reg;
    assign m_tuser  = out_deg_reg;
    always_comb
    begin
        for (int i = 0; i < 6; i++) m_tdata[i*16 +: 16] = out_res_reg[i];
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while held");
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != 2'd3)) else $error("corner count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> count_reg == 2'd0) else $error("count not cleared");
endmodule
`default_nettype wire
